[rtl/ctpd_pkg.sv]
// Shared types and constants for the CD-Text pack demultiplexer.
package ctpd_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [7:0]  TYPE_TITLE        = 8'h80;
   localparam logic [7:0]  TYPE_PERFORMER    = 8'h81;
   localparam logic [6:0]  TRACK_MAX         = 7'h7F;
   localparam logic [6:0]  TRACK_COUNT_RESET = 7'd99;
   localparam logic [16:0] HEADER_LEN        = 17'd4;
   localparam logic [4:0]  PACK_LAST_OFF     = 5'd17;
   localparam logic [4:0]  PAYLOAD_FIRST_OFF = 5'd4;
   localparam logic [4:0]  PAYLOAD_LAST_OFF  = 5'd15;
   localparam logic [17:0] PACK_TAIL         = 18'd17;

   localparam logic [2:0]  CSR_ADDR_TRACK_COUNT = 3'd0;

   // Work passed from the front end to the back end.
   typedef enum logic [1:0] {
      OP_RESTART = 2'd0,
      OP_LOAD    = 2'd1,
      OP_PAYLOAD = 2'd2,
      OP_DONE    = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        perf;
      logic [7:0]  data;
   } op_type;

   typedef enum logic [1:0] {
      EV_CHAR = 2'd0,
      EV_EOS  = 2'd1,
      EV_DONE = 2'd2
   } ev_kind_type;

endpackage

[rtl/ctpd_front.sv]
// Front end: tracks response framing and classifies each byte into back-end work.
module ctpd_front import ctpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] resp_byte,
   input  logic       resp_first,
   output logic       push,
   output op_type     op
);

   typedef enum logic [1:0] {
      CLS_NONE  = 2'd0,
      CLS_TITLE = 2'd1,
      CLS_PERF  = 2'd2
   } cls_type;

   logic        active_ff, active_in;
   logic [16:0] idx_ff, idx_in;
   logic [15:0] len_ff, len_in;
   logic [4:0]  off_ff, off_in;
   cls_type     cls_ff, cls_in;

   logic [15:0] len_now;
   logic        done_hit;
   logic        in_range;

   always_comb begin
      len_now   = (idx_ff == 17'd1) ? {len_ff[15:8], resp_byte} : len_ff;
      done_hit  = (idx_ff == ({1'b0, len_now} + 17'd1));
      in_range  = (({1'b0, idx_ff} + PACK_TAIL) <= ({2'b00, len_now} + 18'd1));

      active_in = active_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      off_in    = off_ff;
      cls_in    = cls_ff;
      push      = 1'b0;
      op.kind   = OP_RESTART;
      op.perf   = (cls_ff == CLS_PERF);
      op.data   = resp_byte;

      if (take) begin
         if (resp_first) begin
            // byte 0 of a new response: high length byte, clear all parse state
            active_in = 1'b1;
            idx_in    = 17'd1;
            len_in    = {resp_byte, 8'h00};
            off_in    = '0;
            cls_in    = CLS_NONE;
            push      = 1'b1;
            op.kind   = OP_RESTART;
         end else if (active_ff) begin
            len_in = len_now;
            if (done_hit) begin
               active_in = 1'b0;
               push      = 1'b1;
               op.kind   = OP_DONE;
            end else begin
               idx_in = idx_ff + 17'd1;
               if (idx_ff >= HEADER_LEN) begin
                  off_in = (off_ff == PACK_LAST_OFF) ? 5'd0 : off_ff + 5'd1;
                  if (off_ff == 5'd0) begin
                     priority if (!in_range)                 cls_in = CLS_NONE;
                     else if (resp_byte == TYPE_TITLE)      cls_in = CLS_TITLE;
                     else if (resp_byte == TYPE_PERFORMER)  cls_in = CLS_PERF;
                     else                                    cls_in = CLS_NONE;
                  end else if (cls_ff != CLS_NONE) begin
                     if (off_ff == 5'd1) begin
                        push    = 1'b1;
                        op.kind = OP_LOAD;
                     end else if (off_ff >= PAYLOAD_FIRST_OFF &&
                                  off_ff <= PAYLOAD_LAST_OFF) begin
                        push    = 1'b1;
                        op.kind = OP_PAYLOAD;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
         len_ff    <= '0;
         off_ff    <= '0;
         cls_ff    <= CLS_NONE;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         len_ff    <= len_in;
         off_ff    <= off_in;
         cls_ff    <= cls_in;
      end
   end

endmodule

[rtl/ctpd_queue.sv]
// Short work queue between the front end and the back end.
module ctpd_queue import ctpd_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output op_type head_op,
   output logic   empty,
   output logic   full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   op_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == FULL_CNT);
   assign head_op = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("work queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("work queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("work queue count out of range");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("work queue count missed a write");

endmodule

[rtl/ctpd_back.sv]
// Back end: per-type track counters, filtering and the result register.
module ctpd_back import ctpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [6:0] track_count,
   input  op_type     head_op,
   input  logic       empty,
   output logic       pop,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic [1:0] rsp_event_kind,
   output logic       rsp_text_kind,
   output logic [6:0] rsp_track_number,
   output logic [7:0] rsp_text_char,
   output logic       rsp_album_text_found
);

   logic [6:0] t_ctr_ff, t_ctr_in;
   logic [6:0] p_ctr_ff, p_ctr_in;
   logic       t_started_ff, t_started_in;
   logic       p_started_ff, p_started_in;
   logic       album_ff, album_in;

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic       tk_ff, tk_in;
   logic [6:0] trk_ff, trk_in;
   logic [7:0] char_ff, char_in;
   logic       found_ff, found_in;

   logic       emit;
   logic [6:0] ctr;
   logic       started;
   logic       keep;
   logic [6:0] ctr_next;
   logic       started_next;

   assign pop = !empty && (!valid_ff || !rsp_stall);

   always_comb begin
      ctr          = head_op.perf ? p_ctr_ff : t_ctr_ff;
      started      = head_op.perf ? p_started_ff : t_started_ff;
      keep         = (ctr <= track_count);
      ctr_next     = ctr;
      started_next = started;

      t_ctr_in     = t_ctr_ff;
      p_ctr_in     = p_ctr_ff;
      t_started_in = t_started_ff;
      p_started_in = p_started_ff;
      album_in     = album_ff;

      emit     = 1'b0;
      kind_in  = kind_ff;
      tk_in    = tk_ff;
      trk_in   = trk_ff;
      char_in  = char_ff;
      found_in = found_ff;

      if (pop) begin
         unique case (head_op.kind)
            OP_RESTART: begin
               t_ctr_in     = '0;
               p_ctr_in     = '0;
               t_started_in = 1'b0;
               p_started_in = 1'b0;
               album_in     = 1'b0;
            end
            OP_LOAD: begin
               // only the first pack of a type sets its counter
               if (!started) begin
                  ctr_next     = head_op.data[6:0];
                  started_next = 1'b1;
               end
            end
            OP_PAYLOAD: begin
               emit     = keep;
               tk_in    = head_op.perf;
               trk_in   = ctr;
               found_in = 1'b0;
               if (head_op.data != 8'h00) begin
                  if (ctr == 7'd0) album_in = 1'b1;
                  kind_in = EV_CHAR;
                  char_in = head_op.data;
               end else begin
                  kind_in = EV_EOS;
                  char_in = 8'h00;
                  if (ctr != TRACK_MAX) ctr_next = ctr + 7'd1;
               end
            end
            OP_DONE: begin
               emit     = 1'b1;
               kind_in  = EV_DONE;
               tk_in    = 1'b0;
               trk_in   = '0;
               char_in  = 8'h00;
               found_in = album_ff;
            end
            default: ;
         endcase
         if (head_op.kind == OP_LOAD || head_op.kind == OP_PAYLOAD) begin
            if (head_op.perf) begin
               p_ctr_in     = ctr_next;
               p_started_in = started_next;
            end else begin
               t_ctr_in     = ctr_next;
               t_started_in = started_next;
            end
         end
      end

      valid_in = pop ? emit : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ctr_ff     <= '0;
         p_ctr_ff     <= '0;
         t_started_ff <= 1'b0;
         p_started_ff <= 1'b0;
         album_ff     <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         t_ctr_ff     <= t_ctr_in;
         p_ctr_ff     <= p_ctr_in;
         t_started_ff <= t_started_in;
         p_started_ff <= p_started_in;
         album_ff     <= album_in;
         valid_ff     <= valid_in;
      end
   end

   // hold the payload unless a new beat is loaded
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         kind_ff  <= kind_in;
         tk_ff    <= tk_in;
         trk_ff   <= trk_in;
         char_ff  <= char_in;
         found_ff <= found_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_event_kind       = kind_ff;
   assign rsp_text_kind        = tk_ff;
   assign rsp_track_number     = trk_ff;
   assign rsp_text_char        = char_ff;
   assign rsp_album_text_found = found_ff;

   a_pop_only_when_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!valid_ff || !rsp_stall))
      else $error("work taken while result register is blocked");

   a_counter_saturates: assert property (@(posedge clock) disable iff (reset)
      ($past(t_ctr_ff) == TRACK_MAX && !($past(pop) && $past(head_op.kind) == OP_RESTART))
      |-> (t_ctr_ff == TRACK_MAX))
      else $error("title counter wrapped past its maximum");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == EV_DONE) |-> (trk_ff == 7'd0 && char_ff == 8'h00 && !tk_ff))
      else $error("completion beat carries text fields");

endmodule

[rtl/cd_text_pack_demux.sv]
// Top level of the CD-Text pack demultiplexer: register port, front end, queue, back end.
//
//  channel  dir   handshake                fields
//  req      in    req_valid / req_stall    req_resp_byte, req_resp_first
//  rsp      out   rsp_valid / rsp_stall    rsp_event_kind, rsp_text_kind, rsp_track_number,
//                                          rsp_text_char, rsp_album_text_found
//  csr      in    APB write/read           track_count at byte address 0
//
// One byte is accepted per cycle while req_stall is low. The front end classifies it
// combinationally; the op is registered in the queue, then in the back-end result register.
// The back end sets throughput: one queued op per cycle while its result is not stalled.
// Synchronous reset clears framing, counters and the queue; track_count returns to 99.
// req_stall rises only when the work queue is full; it fills while rsp_stall holds a result.
module cd_text_pack_demux import ctpd_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_resp_byte,
   input  logic        req_resp_first,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic        rsp_text_kind,
   output logic [6:0]  rsp_track_number,
   output logic [7:0]  rsp_text_char,
   output logic        rsp_album_text_found,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [6:0] track_count_ff, track_count_in;
   logic       csr_wr;
   logic       take;
   logic       push;
   op_type     push_op;
   op_type     head_op;
   logic       q_empty;
   logic       q_full;
   logic       pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      track_count_in = track_count_ff;
      if (csr_wr && csr_paddr[2] == CSR_ADDR_TRACK_COUNT[2]) begin
         track_count_in = csr_pwdata[6:0];
      end
      csr_prdata = (csr_paddr[2] == CSR_ADDR_TRACK_COUNT[2]) ?
                   {25'd0, track_count_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_count_ff <= TRACK_COUNT_RESET;
      end else begin
         track_count_ff <= track_count_in;
      end
   end

   assign req_stall = q_full;
   assign take      = req_valid && !req_stall;

   ctpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .resp_byte  (req_resp_byte),
      .resp_first (req_resp_first),
      .push       (push),
      .op         (push_op)
   );

   ctpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .empty   (q_empty),
      .full    (q_full)
   );

   ctpd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .track_count          (track_count_ff),
      .head_op              (head_op),
      .empty                (q_empty),
      .pop                  (pop),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_event_kind       (rsp_event_kind),
      .rsp_text_kind        (rsp_text_kind),
      .rsp_track_number     (rsp_track_number),
      .rsp_text_char        (rsp_text_char),
      .rsp_album_text_found (rsp_album_text_found)
   );

endmodule
